[rtl/core/assert_macros.svh]
// assertion macros for the rtl of the interval overlap classifier
// no dependencies; included by interval_overlap_classifier, the file that carries concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ioc_pkg.sv]
// package of the interval overlap classifier: item types, class codes, widths
// no dependencies
`timescale 1ns / 1ps

package ioc_pkg;

  // result class codes
  localparam logic [2:0] CLS_HALF_LONG  = 3'd0;
  localparam logic [2:0] CLS_HALF_SHORT = 3'd1;
  localparam logic [2:0] CLS_SMALL      = 3'd2;
  localparam logic [2:0] CLS_DISJOINT   = 3'd3;
  localparam logic [2:0] CLS_MALFORMED  = 3'd4;

  localparam logic [7:0] GAP_TOL_RESET = 8'd5;

  // interval length 1..65536
  localparam int LEN_W = 17;
  // magnitude of 16 * overlap, at most 2^20
  localparam int DVD_W = 21;
  // quotient magnitude stays below 4096
  localparam int DIV_BITS = 12;
  localparam int CMP_W = LEN_W + DIV_BITS;
  // default quotient bits resolved per divider stage
  localparam int DIV_STEPS_DEF = 2;

  typedef struct packed {
    logic signed [15:0] first_begin;
    logic signed [15:0] first_finish;
    logic signed [15:0] second_begin;
    logic signed [15:0] second_finish;
  } ioc_in_t;

  typedef struct packed {
    logic [2:0]  overlap_class;
    logic [15:0] ratio_first;
    logic [15:0] ratio_second;
  } ioc_out_t;

  // item state inside the divider pipeline
  typedef struct packed {
    logic [2:0]          cls;
    logic [15:0]         gap;
    logic                neg;
    logic [LEN_W-1:0]    len1;
    logic [LEN_W-1:0]    len2;
    logic [DVD_W-1:0]    rem1;
    logic [DVD_W-1:0]    rem2;
    logic [DIV_BITS-1:0] q1;
    logic [DIV_BITS-1:0] q2;
  } ioc_div_t;

endpackage

[rtl/core/interval_overlap_classifier.sv]
// from input accept to output valid an item passes front stages a and b, the divider stages and the output register
// throughput: one item per cycle; every stage has its own valid bit and holds under stall
// the restoring dividers resolve DIV_STEPS quotient bits per stage
// reset (synchronous, active high) empties the pipeline and sets gap_tolerance to 5
// depends on ioc_pkg, ioc_front, ioc_div_stage and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module interval_overlap_classifier #(
  parameter int DIV_STEPS = ioc_pkg::DIV_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input item channel
  input  logic              in_valid,
  output logic              in_ready,
  input  ioc_pkg::ioc_in_t  in_data,
  // result item channel
  output logic              out_valid,
  input  logic              out_ready,
  output ioc_pkg::ioc_out_t out_data,
  // tolerance register write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  // number of divider stages; the last one may resolve fewer bits
  localparam int NUM_STAGES = (ioc_pkg::DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;

  logic [7:0] gap_tolerance;

  // chain of divider stages, index 0 is the front output
  logic              stage_valid [NUM_STAGES+1];
  logic              stage_ready [NUM_STAGES+1];
  ioc_pkg::ioc_div_t stage_data  [NUM_STAGES+1];

  ioc_pkg::ioc_div_t last;
  ioc_pkg::ioc_out_t out_next;
  logic              last_ready;

  // tolerance register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_tolerance <= ioc_pkg::GAP_TOL_RESET;
    end else if (cfg_valid) begin
      gap_tolerance <= cfg_data;
    end
  end

  // bounds, gap test, class and dividend in two stages
  ioc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .gap_tolerance (gap_tolerance),
    .down_valid    (stage_valid[0]),
    .down_ready    (stage_ready[0]),
    .down_data     (stage_data[0])
  );

  // both ratios are divided in lockstep, highest quotient bit first
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_div
    ioc_div_stage #(
      .STEPS     (DIV_STEPS),
      .FIRST_BIT (ioc_pkg::DIV_BITS - 1 - k * DIV_STEPS)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (stage_valid[k]),
      .up_ready   (stage_ready[k]),
      .up_data    (stage_data[k]),
      .down_valid (stage_valid[k+1]),
      .down_ready (stage_ready[k+1]),
      .down_data  (stage_data[k+1])
    );
  end

  assign last = stage_data[NUM_STAGES];

  // final select: quotient sign applied here; zeros for malformed, gap and zero for disjoint
  always_comb begin
    out_next.overlap_class = last.cls;
    out_next.ratio_first   = last.neg ? 16'(16'd0 - 16'(last.q1)) : 16'(last.q1);
    out_next.ratio_second  = last.neg ? 16'(16'd0 - 16'(last.q2)) : 16'(last.q2);
    case (last.cls)
      ioc_pkg::CLS_MALFORMED: begin
        out_next.ratio_first  = 16'd0;
        out_next.ratio_second = 16'd0;
      end
      ioc_pkg::CLS_DISJOINT: begin
        out_next.ratio_first  = last.gap;
        out_next.ratio_second = 16'd0;
      end
      default: begin
      end
    endcase
  end

  // output register parts the result side from the pipeline
  assign last_ready              = !out_valid || out_ready;
  assign stage_ready[NUM_STAGES] = last_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (last_ready) begin
      out_valid <= stage_valid[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (last_ready && stage_valid[NUM_STAGES]) begin
      out_data <= out_next;
    end
  end

  // checks on the result side
  logic out_malformed, out_disjoint, out_half_long;
  logic ratios_zero, first_in_band, second_in_band;

  assign out_malformed  = out_valid && out_data.overlap_class == ioc_pkg::CLS_MALFORMED;
  assign out_disjoint   = out_valid && out_data.overlap_class == ioc_pkg::CLS_DISJOINT;
  assign out_half_long  = out_valid && out_data.overlap_class == ioc_pkg::CLS_HALF_LONG;
  assign ratios_zero    = out_data.ratio_first == 16'd0 && out_data.ratio_second == 16'd0;
  assign first_in_band  = out_data.ratio_first >= 16'd8 && out_data.ratio_first <= 16'd16;
  assign second_in_band = out_data.ratio_second >= 16'd8 && out_data.ratio_second <= 16'd16;

  // over half of the longer interval means over half of each, so both ratios are 8..16
  `ASSERT_IMPLY(a_half_long_band, clk, rst, out_half_long, first_in_band && second_in_band, "ratio out of band")
  `ASSERT_IMPLY(a_malformed_zero, clk, rst, out_malformed, ratios_zero, "malformed item with ratio")
  `ASSERT_IMPLY(a_disjoint_second, clk, rst, out_disjoint, out_data.ratio_second == 16'd0, "disjoint ratio")
  // input can only stall when the whole pipeline backs up from a held result
  `ASSERT_IMPLY(a_stall_source, clk, rst, !in_ready, out_valid && !out_ready, "input stalled without cause")

endmodule

[rtl/core/ioc_front.sv]
// front of the classifier: interval bounds, gap test, lengths, class, dividend
// depends on ioc_pkg; two register stages with their own valid bits
`timescale 1ns / 1ps

module ioc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ioc_pkg::ioc_in_t  in_data,
  input  logic [7:0]        gap_tolerance,
  output logic              down_valid,
  input  logic              down_ready,
  output ioc_pkg::ioc_div_t down_data
);

  typedef struct packed {
    logic                       malformed;
    logic                       disjoint;
    logic [15:0]                gap;
    logic signed [17:0]         ov;
    logic [ioc_pkg::LEN_W-1:0]  len1;
    logic [ioc_pkg::LEN_W-1:0]  len2;
  } front_a_t;

  logic     valid_a;
  logic     ready_a;
  front_a_t data_a;
  front_a_t data_a_next;
  logic     ready_b;
  ioc_pkg::ioc_div_t data_b_next;

  // stage a: bounds, gap test and lengths
  always_comb begin
    logic signed [17:0] b1, e1, b2, e2, lo, hi;
    b1 = 18'(in_data.first_begin);
    e1 = 18'(in_data.first_finish);
    b2 = 18'(in_data.second_begin);
    e2 = 18'(in_data.second_finish);
    lo = (b1 > b2) ? b1 : b2;
    hi = (e1 < e2) ? e1 : e2;
    data_a_next.malformed = (e1 < b1) || (e2 < b2);
    data_a_next.disjoint  = lo > (hi + $signed({10'd0, gap_tolerance}));
    data_a_next.gap       = 16'(lo - hi);
    data_a_next.ov        = hi - lo + 18'sd1;
    data_a_next.len1      = ioc_pkg::LEN_W'(e1 - b1 + 18'sd1);
    data_a_next.len2      = ioc_pkg::LEN_W'(e2 - b2 + 18'sd1);
  end

  // stage b: class and dividend magnitude
  always_comb begin
    logic [ioc_pkg::LEN_W-1:0] shorter, longer;
    logic signed [18:0]        twice;
    logic signed [21:0]        scaled;
    shorter = (data_a.len1 < data_a.len2) ? data_a.len1 : data_a.len2;
    longer  = (data_a.len1 > data_a.len2) ? data_a.len1 : data_a.len2;
    twice   = {data_a.ov, 1'b0};
    scaled  = {data_a.ov, 4'd0};
    data_b_next = '0;
    if (data_a.malformed) begin
      data_b_next.cls = ioc_pkg::CLS_MALFORMED;
    end else if (data_a.disjoint) begin
      data_b_next.cls = ioc_pkg::CLS_DISJOINT;
    end else if (twice > $signed({2'd0, longer})) begin
      data_b_next.cls = ioc_pkg::CLS_HALF_LONG;
    end else if (twice > $signed({2'd0, shorter})) begin
      data_b_next.cls = ioc_pkg::CLS_HALF_SHORT;
    end else begin
      data_b_next.cls = ioc_pkg::CLS_SMALL;
    end
    data_b_next.gap  = data_a.gap;
    data_b_next.neg  = data_a.ov[17];
    data_b_next.len1 = data_a.len1;
    data_b_next.len2 = data_a.len2;
    data_b_next.rem1 = ioc_pkg::DVD_W'(data_a.ov[17] ? -scaled : scaled);
    data_b_next.rem2 = data_b_next.rem1;
  end

  assign ready_b  = !down_valid || down_ready;
  assign ready_a  = !valid_a || ready_b;
  assign in_ready = ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a    <= 1'b0;
      down_valid <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a <= in_valid;
      end
      if (ready_b) begin
        down_valid <= valid_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      data_a <= data_a_next;
    end
    if (ready_b && valid_a) begin
      down_data <= data_b_next;
    end
  end

endmodule

[rtl/core/ioc_div_stage.sv]
// one stage of the two restoring dividers, STEPS quotient bits per stage
// depends on ioc_pkg; holds its item while the next stage is full
`timescale 1ns / 1ps

module ioc_div_stage #(
  parameter int STEPS     = ioc_pkg::DIV_STEPS_DEF,
  parameter int FIRST_BIT = ioc_pkg::DIV_BITS - 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  ioc_pkg::ioc_div_t up_data,
  output logic              down_valid,
  input  logic              down_ready,
  output ioc_pkg::ioc_div_t down_data
);

  ioc_pkg::ioc_div_t data_next;

  always_comb begin
    logic [ioc_pkg::CMP_W-1:0] sh1, sh2, r1, r2;
    data_next = up_data;
    sh1 = '0;
    sh2 = '0;
    r1  = '0;
    r2  = '0;
    for (int j = 0; j < STEPS; j++) begin
      if (FIRST_BIT - j >= 0) begin
        sh1 = ioc_pkg::CMP_W'(up_data.len1) << (FIRST_BIT - j);
        sh2 = ioc_pkg::CMP_W'(up_data.len2) << (FIRST_BIT - j);
        r1  = ioc_pkg::CMP_W'(data_next.rem1);
        r2  = ioc_pkg::CMP_W'(data_next.rem2);
        data_next.q1 = {data_next.q1[ioc_pkg::DIV_BITS-2:0], r1 >= sh1};
        data_next.q2 = {data_next.q2[ioc_pkg::DIV_BITS-2:0], r2 >= sh2};
        if (r1 >= sh1) begin
          data_next.rem1 = ioc_pkg::DVD_W'(r1 - sh1);
        end
        if (r2 >= sh2) begin
          data_next.rem2 = ioc_pkg::DVD_W'(r2 - sh2);
        end
      end
    end
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_data <= data_next;
    end
  end

endmodule

[tb/interval_overlap_classifier_test.sv]
// self-checking testbench of interval_overlap_classifier: directed table, then random pairs
// depends on ioc_pkg and the interval_overlap_classifier rtl
`timescale 1ns / 1ps

module interval_overlap_classifier_test;

  localparam int RATIO_SCALE = 16;
  // settling margin, more than the pipeline depth
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 260;

  // one row of the directed table; expectation typed in only where has_exp is set
  typedef struct packed {
    int         fb;
    int         ff;
    int         sb;
    int         sf;
    bit         has_exp;
    logic [2:0] cls;
    int         r1;
    int         r2;
  } dir_row_t;

  localparam int DIRECTED_ROWS = 18;
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // both intervals span the whole coordinate range
    '{-32768, 32767, -32768, 32767, 1'b1, ioc_pkg::CLS_HALF_LONG, 16, 16},
    // single identical points
    '{0, 0, 0, 0, 1'b1, ioc_pkg::CLS_HALF_LONG, 16, 16},
    // malformed first, malformed second, both malformed at the extremes
    '{5, 4, 0, 10, 1'b1, ioc_pkg::CLS_MALFORMED, 0, 0},
    '{0, 10, -1, -2, 1'b1, ioc_pkg::CLS_MALFORMED, 0, 0},
    '{32767, -32768, 32767, -32768, 1'b1, ioc_pkg::CLS_MALFORMED, 0, 0},
    // malformed takes precedence over a gap that would read as disjoint
    '{10, 0, 100, 200, 1'b1, ioc_pkg::CLS_MALFORMED, 0, 0},
    // widest possible gap, both orders
    '{-32768, -32768, 32767, 32767, 1'b1, ioc_pkg::CLS_DISJOINT, 65535, 0},
    '{32767, 32767, -32768, -32768, 1'b1, ioc_pkg::CLS_DISJOINT, 65535, 0},
    // adjacent, near-touching right at the tolerance, one past it
    '{0, 9, 10, 19, 1'b0, ioc_pkg::CLS_HALF_LONG, 0, 0},
    '{0, 9, 14, 20, 1'b0, ioc_pkg::CLS_HALF_LONG, 0, 0},
    '{0, 9, 15, 20, 1'b0, ioc_pkg::CLS_HALF_LONG, 0, 0},
    // containment, a short tail, exactly half
    '{0, 99, 40, 59, 1'b0, ioc_pkg::CLS_HALF_LONG, 0, 0},
    '{0, 99, 90, 199, 1'b0, ioc_pkg::CLS_HALF_LONG, 0, 0},
    '{0, 9, 5, 14, 1'b0, ioc_pkg::CLS_HALF_LONG, 0, 0},
    // one-point intervals at the coordinate extremes against the full range
    '{32767, 32767, -32768, 32767, 1'b0, ioc_pkg::CLS_HALF_LONG, 0, 0},
    '{-32768, -32768, -32768, 32767, 1'b0, ioc_pkg::CLS_HALF_LONG, 0, 0},
    // around zero and alternating bit patterns
    '{-1, 0, -1, -1, 1'b0, ioc_pkg::CLS_HALF_LONG, 0, 0},
    '{-21846, 21845, -100, 100, 1'b0, ioc_pkg::CLS_HALF_LONG, 0, 0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ioc_pkg::ioc_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ioc_pkg::ioc_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_data = '0;

  // tolerance as the block should hold it
  logic [7:0]        gap_tol = ioc_pkg::GAP_TOL_RESET;
  // results still owed by the block, oldest first
  ioc_pkg::ioc_out_t overlap_due [$];
  // typed-in expectation travelling with the item on the input channel
  bit                fixed_valid = 1'b0;
  ioc_pkg::ioc_out_t fixed_result = '0;
  int                in_idle_pct = 0;
  int                out_stall_pct = 0;
  int                mismatch_count = 0;

  interval_overlap_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // generous limit; the slowest correct run needs well under a tenth of this
  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

  // expected result of one interval pair under a given tolerance
  function automatic ioc_pkg::ioc_out_t classify_pair(ioc_pkg::ioc_in_t p, logic [7:0] tol);
    int b1, e1, b2, e2, lo, hi, ovl, len1, len2, shorter, longer;
    ioc_pkg::ioc_out_t r;
    b1 = p.first_begin;
    e1 = p.first_finish;
    b2 = p.second_begin;
    e2 = p.second_finish;
    r = '0;
    // malformed check comes ahead of the gap test
    if (e1 < b1 || e2 < b2) begin
      r.overlap_class = ioc_pkg::CLS_MALFORMED;
      return r;
    end
    lo = (b1 > b2) ? b1 : b2;
    hi = (e1 < e2) ? e1 : e2;
    if (lo > hi + int'(tol)) begin
      r.overlap_class = ioc_pkg::CLS_DISJOINT;
      r.ratio_first = 16'(lo - hi);
      return r;
    end
    // near-touching pairs give a zero or negative overlap here
    ovl = hi - lo + 1;
    len1 = e1 - b1 + 1;
    len2 = e2 - b2 + 1;
    shorter = (len1 < len2) ? len1 : len2;
    longer = (len1 > len2) ? len1 : len2;
    if (2 * ovl > longer) begin
      r.overlap_class = ioc_pkg::CLS_HALF_LONG;
    end else if (2 * ovl > shorter) begin
      r.overlap_class = ioc_pkg::CLS_HALF_SHORT;
    end else begin
      r.overlap_class = ioc_pkg::CLS_SMALL;
    end
    // int division truncates toward zero, then keep the low 16 bits
    r.ratio_first = 16'((RATIO_SCALE * ovl) / len1);
    r.ratio_second = 16'((RATIO_SCALE * ovl) / len2);
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  // random pair, mostly well formed and clustered around the class boundaries
  function automatic ioc_pkg::ioc_in_t make_pair(logic [7:0] tol);
    int mode, b1, e1, b2, e2, span1, span2, off, tmp;
    ioc_pkg::ioc_in_t p;
    mode = int'($urandom_range(0, 99));
    span1 = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 65535))
                                         : int'($urandom_range(0, 300));
    span2 = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 65535))
                                         : int'($urandom_range(0, 300));
    b1 = int'($signed(16'($urandom)));
    e1 = b1 + span1;
    if (mode < 35) begin
      // partial overlap, sometimes just short of it
      off = int'($urandom_range(0, span1 + 20)) - 10;
      b2 = b1 + off;
      e2 = b2 + span2;
    end else if (mode < 55) begin
      // gap around the tolerance boundary
      b2 = e1 + 1 + int'($urandom_range(0, int'(tol) + 3));
      e2 = b2 + span2;
    end else if (mode < 70) begin
      // second inside the first, identical now and then
      off = int'($urandom_range(0, span1));
      b2 = b1 + off;
      e2 = b2 + int'($urandom_range(0, span1 - off));
      if ($urandom_range(0, 7) == 0) begin
        b2 = b1;
        e2 = e1;
      end
    end else if (mode < 85) begin
      // well formed pair with one interval turned around
      b2 = b1 + int'($urandom_range(0, span1));
      e2 = b2 + span2 + 1;
      if ($urandom_range(0, 1) == 1) begin
        tmp = b2;
        b2 = e2;
        e2 = tmp;
      end else begin
        e1 = b1 - 1 - int'($urandom_range(0, 300));
      end
    end else begin
      // raw noise over the full field range
      b1 = int'($signed(16'($urandom)));
      e1 = int'($signed(16'($urandom)));
      b2 = int'($signed(16'($urandom)));
      e2 = int'($signed(16'($urandom)));
    end
    if ($urandom_range(0, 1) == 1) begin
      p.first_begin = clip16(b1);
      p.first_finish = clip16(e1);
      p.second_begin = clip16(b2);
      p.second_finish = clip16(e2);
    end else begin
      p.first_begin = clip16(b2);
      p.first_finish = clip16(e2);
      p.second_begin = clip16(b1);
      p.second_finish = clip16(e1);
    end
    return p;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // entered and left at a falling edge; valid stays high on the way out
  task automatic send_pair(ioc_pkg::ioc_in_t p, bit has_fixed, ioc_pkg::ioc_out_t fixed);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    fixed_valid = has_fixed;
    fixed_result = fixed;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // stop sending and let every owed result come out
  task automatic drain;
    in_valid <= 1'b0;
    while (overlap_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_tolerance(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n, int in_pct, int out_pct);
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    repeat (n) send_pair(make_pair(gap_tol), 1'b0, '0);
    drain();
  endtask

  // receiver: random back-pressure at the rate of the current phase
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= out_stall_pct);
  end

  // scoreboard: sample both channels and the register port at the rising edge
  always @(posedge clk) begin : scoreboard
    ioc_pkg::ioc_out_t want;
    if (rst) begin
      gap_tol = ioc_pkg::GAP_TOL_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (overlap_due.size() == 0) begin
          flag_mismatch("result with no item pending, class", out_data.overlap_class, -1);
        end else begin
          want = overlap_due.pop_front();
          if (out_data.overlap_class != want.overlap_class) begin
            flag_mismatch("overlap_class", out_data.overlap_class, want.overlap_class);
          end
          if (out_data.ratio_first != want.ratio_first) begin
            flag_mismatch("ratio_first", out_data.ratio_first, want.ratio_first);
          end
          if (out_data.ratio_second != want.ratio_second) begin
            flag_mismatch("ratio_second", out_data.ratio_second, want.ratio_second);
          end
        end
      end
      if (in_valid && in_ready) begin
        overlap_due.push_back(fixed_valid ? fixed_result : classify_pair(in_data, gap_tol));
      end
      if (cfg_valid && cfg_ready) begin
        gap_tol = cfg_data;
      end
    end
  end

  initial begin : stimulus
    ioc_pkg::ioc_in_t  p;
    ioc_pkg::ioc_out_t fixed;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table at the reset tolerance, no idling
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      p.first_begin = 16'(DIRECTED[i].fb);
      p.first_finish = 16'(DIRECTED[i].ff);
      p.second_begin = 16'(DIRECTED[i].sb);
      p.second_finish = 16'(DIRECTED[i].sf);
      fixed.overlap_class = DIRECTED[i].cls;
      fixed.ratio_first = 16'(DIRECTED[i].r1);
      fixed.ratio_second = 16'(DIRECTED[i].r2);
      send_pair(p, DIRECTED[i].has_exp, fixed);
    end
    drain();

    // zero tolerance, steady streaming both ways
    write_tolerance(8'd0);
    run_random(RANDOM_PER_PHASE, 0, 0);
    // widest tolerance, sparse input
    write_tolerance(8'd255);
    run_random(RANDOM_PER_PHASE, 68, 0);
    // some tolerance in between, heavy back-pressure
    write_tolerance(8'($urandom_range(1, 254)));
    run_random(RANDOM_PER_PHASE, 0, 68);
    // back to the reset value, light idling on both sides
    write_tolerance(ioc_pkg::GAP_TOL_RESET);
    run_random(RANDOM_PER_PHASE, 7, 7);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
